/* src/timer_expiry_manager_unit_macros.svh */
// Assertion macros used by the timer expiry manager checker
`ifndef TIMER_EXPIRY_MANAGER_UNIT_MACROS_SVH
`define TIMER_EXPIRY_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TEMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TEMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/temu_pkg.sv */
// Types and constants shared by the timer expiry manager modules
package temu_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RES        = 16;
  localparam int IDX_W          = 4;
  localparam int IN_DATA_W      = 136;
  localparam int OUT_DATA_W     = 8;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_STOP   = 2'd1,
    OP_MANAGE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic simple;     // arm, stop or query beat accepted this cycle
    logic mgr_start;  // manage beat accepted this cycle
    logic scan_issue; // read one table entry
    logic fire;       // fire the best entry found by the pass
    logic none;       // report that nothing was due
  } temu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // read address is at the final slot
    logic found;      // the pass found a due entry
    logic fire_last;  // this fire is the final result of the manage op
  } temu_sts_t;

  // One result item
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic             pend;
    logic             last;
  } temu_res_t;

endpackage

/* src/temu_ctrl.sv */
// Controller state machine for the timer expiry manager
module temu_ctrl
  import temu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  op_t       in_op,
  output logic      in_tready,
  input  logic      out_free,
  input  temu_sts_t sts,
  output temu_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIRE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_MANAGE) begin
            cmd.mgr_start = 1'b1;
            state_nxt     = ST_SCAN;
          end else begin
            cmd.simple = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last read data is compared this cycle
        state_nxt = ST_FIRE;
      end
      ST_FIRE: begin
        if (out_free) begin
          if (sts.found) begin
            cmd.fire  = 1'b1;
            state_nxt = sts.fire_last ? ST_IDLE : ST_SCAN;
          end else begin
            cmd.none  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* src/temu_dp.sv */
// Datapath: timer table memory, pending flags, scan compare and result build
module temu_dp
  import temu_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  temu_cmd_t        cmd,
  input  op_t              in_op,
  input  logic [IDX_W-1:0] in_timer_index,
  input  logic [63:0]      in_ticks,
  input  logic             in_periodic,
  input  logic [63:0]      in_now,
  output temu_sts_t        sts,
  output temu_res_t        res
);

  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W  = $clog2(MAX_RES);

  typedef struct packed {
    logic [63:0] exp;
    logic [63:0] per;
    logic [31:0] ord;
  } ent_t;

  // Timer table, one write and one registered read per cycle
  ent_t mem [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] pend_r;
  logic [NUM_TIMERS-1:0] due_r;
  logic [31:0]           order_r;
  logic [63:0]           now_r;
  logic                  first_r;
  logic [CNT_W-1:0]      n_r;
  logic [SLOT_W-1:0]     cnt_r;
  logic                  rd_vld_r;
  logic [SLOT_W-1:0]     rd_slot_r;
  ent_t                  rd_data_r;
  logic                  found_r;
  logic [SLOT_W-1:0]     best_slot_r;
  logic [63:0]           best_exp_r;
  logic [63:0]           best_per_r;
  logic [31:0]           best_age_r;

  logic              idx_ok;
  logic [SLOT_W-1:0] in_slot;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  ent_t              wr_data;
  logic [31:0]       age;
  logic              cand;
  logic              better;
  logic              rearm;
  logic [NUM_TIMERS-1:0] due_rest;

  assign idx_ok  = 32'(in_timer_index) < NUM_TIMERS;
  assign in_slot = SLOT_W'(in_timer_index);
  assign rearm   = best_per_r != 64'd0;

  // Table write: arm from the input beat, or re-arm of a fired periodic timer
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_slot;
    wr_data.exp = in_now + in_ticks;
    wr_data.per = in_periodic ? in_ticks : 64'd0;
    wr_data.ord = order_r;
    if (cmd.simple && in_op == OP_ARM && idx_ok) begin
      wr_en = 1'b1;
    end else if (cmd.fire && rearm) begin
      wr_en       = 1'b1;
      wr_addr     = best_slot_r;
      wr_data.exp = best_exp_r + best_per_r;
      wr_data.per = best_per_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.scan_issue) rd_data_r <= mem[cnt_r];
  end

  // Compare of the entry read last cycle against the best so far
  assign age    = order_r - rd_data_r.ord;
  assign cand   = first_r ? (pend_r[rd_slot_r] && rd_data_r.exp <= now_r)
                          : due_r[rd_slot_r];
  assign better = !found_r || (rd_data_r.exp < best_exp_r) ||
                  (rd_data_r.exp == best_exp_r && age > best_age_r);

  assign due_rest       = due_r & ~({{(NUM_TIMERS-1){1'b0}}, 1'b1} << best_slot_r);
  assign sts.scan_last  = cnt_r == SLOT_W'(NUM_TIMERS - 1);
  assign sts.found      = found_r;
  assign sts.fire_last  = (n_r == CNT_W'(MAX_RES - 1)) || (due_rest == '0);

  // Control state of the scan passes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      order_r  <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      first_r  <= 1'b0;
      n_r      <= '0;
      cnt_r    <= '0;
      due_r    <= '0;
    end else begin
      rd_vld_r <= cmd.scan_issue;
      if (cmd.simple && idx_ok) begin
        if (in_op == OP_ARM) begin
          pend_r[in_slot] <= 1'b1;
          order_r         <= order_r + 32'd1;
        end else if (in_op == OP_STOP) begin
          pend_r[in_slot] <= 1'b0;
        end
      end
      if (cmd.mgr_start) begin
        first_r <= 1'b1;
        n_r     <= '0;
        cnt_r   <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan_issue) cnt_r <= cnt_r + SLOT_W'(1);
      if (rd_vld_r) begin
        if (first_r) due_r[rd_slot_r] <= cand;
        if (cand && better) found_r <= 1'b1;
      end
      if (cmd.fire) begin
        first_r            <= 1'b0;
        n_r                <= n_r + CNT_W'(1);
        cnt_r              <= '0;
        found_r            <= 1'b0;
        due_r[best_slot_r] <= 1'b0;
        if (rearm) order_r <= order_r + 32'd1;
        else       pend_r[best_slot_r] <= 1'b0;
      end
    end
  end

  // Best entry payload, manage time and scan pipeline tags
  always_ff @(posedge clk) begin
    rd_slot_r <= cnt_r;
    if (cmd.mgr_start) now_r <= in_now;
    if (rd_vld_r && cand && better) begin
      best_slot_r <= rd_slot_r;
      best_exp_r  <= rd_data_r.exp;
      best_per_r  <= rd_data_r.per;
      best_age_r  <= age;
    end
  end

  // Result item for whichever command emits this cycle
  always_comb begin
    res.kind = KIND_DONE;
    res.idx  = in_timer_index;
    res.pend = 1'b0;
    res.last = 1'b1;
    if (cmd.fire) begin
      res.kind = KIND_FIRED;
      res.idx  = IDX_W'(best_slot_r);
      res.last = sts.fire_last;
    end else if (cmd.none) begin
      res.kind = KIND_NONE;
      res.idx  = '0;
    end else if (in_op == OP_QUERY) begin
      res.kind = KIND_QUERY;
      res.pend = idx_ok && pend_r[in_slot];
    end
  end

endmodule

/* src/timer_expiry_manager_unit.sv */
// Arm, stop and query give their result in the cycle after the beat is taken,
// and one such beat is taken every cycle while the output register drains.
// Manage: every pass reads the whole timer table, one slot a cycle, then goes through a
// drain state and a fire state, which waits for a free output register to give its result.
// Reset clears the pending flags, the arming counter and the control state; the
// timer table itself holds no reset value; all slots are read, only pending ones are used.
module timer_expiry_manager_unit
  import temu_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // timer_index[3:0], ticks[67:4], periodic[68], now[132:69]
  input  logic [1:0]            in_tuser,  // op[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // fired_index[3:0], pending_answer[4]
  output logic [1:0]            out_tuser, // kind[1:0]
  output logic                  out_tlast
);

  temu_cmd_t cmd;
  temu_sts_t sts;
  temu_res_t res;
  op_t       in_op;
  logic      out_free;
  logic      emit;
  logic      out_valid_r;
  temu_res_t out_res_r;

  assign in_op    = op_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;
  assign emit     = cmd.simple || cmd.fire || cmd.none;

  temu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_op),
    .in_tready (in_tready),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd)
  );

  temu_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_timer_index (in_tdata[3:0]),
    .in_ticks       (in_tdata[67:4]),
    .in_periodic    (in_tdata[68]),
    .in_now         (in_tdata[132:69]),
    .sts            (sts),
    .res            (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - IDX_W - 1){1'b0}}, out_res_r.pend, out_res_r.idx};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;

endmodule

/* src/temu_checker.sv */
// Port-level checker for the timer expiry manager, bound to the top level
`include "timer_expiry_manager_unit_macros.svh"

module temu_checker
  import temu_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // A stalled result beat holds
  `TEMU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result beat changed")

  // Only fired results may be followed by more results of the same op
  `TEMU_ASSERT_NOW(a_single_last, out_tvalid && out_tuser != KIND_FIRED, out_tlast, "non-fire result without last")

  // A nothing-due result carries no slot and no pending flag
  `TEMU_ASSERT_NOW(a_none_empty, out_tvalid && out_tuser == KIND_NONE, out_tdata == '0, "nothing-due result has data")

  // Arm, stop and query answer in the next cycle
  `TEMU_ASSERT_NEXT(a_simple_resp, in_tvalid && in_tready && in_tuser != OP_MANAGE, out_tvalid && out_tlast && out_tuser != KIND_FIRED && out_tuser != KIND_NONE, "simple op not answered")

endmodule

bind timer_expiry_manager_unit temu_checker u_temu_checker (.*);
